// File: rtl/core/srdd_pkg.sv
// Shared types, codes and default sizes of the sparse row store.
package srdd_pkg;

   localparam int DEF_MAX_ENTRIES = 1024;
   localparam int DEF_MAX_ROWS    = 256;
   localparam int DEF_COL_BITS    = 16;
   localparam int DEF_VALUE_BITS  = 16;
   localparam int DEF_FRAC_BITS   = 8;

   localparam int RES_BITS = 48;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_DOT    = 2'd2;
   localparam logic [1:0] CMD_DIST   = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_ORDER  = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;
   localparam logic [1:0] STAT_NO_ROW = 2'd3;

   // What the arithmetic unit does with one entry read from the store.
   localparam logic [1:0] KIND_SQ    = 2'd0;
   localparam logic [1:0] KIND_CROSS = 2'd1;
   localparam logic [1:0] KIND_LOOK  = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         row_a;
      logic [7:0]         row_b;
      logic [15:0]        column;
      logic signed [15:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic signed [RES_BITS-1:0] result_value;
      logic [8:0]                 rows_stored;
      logic [10:0]                entries_stored;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       clear;
      logic       dist_mode;
   } mac_ctrl_type;

   typedef struct packed {
      logic busy;
      logic found;
   } mac_stat_type;

endpackage

// File: rtl/core/srdd_mac.sv
// Shared multiply-accumulate unit with column match, first-match capture and saturation.
module srdd_mac #(
   parameter int COL_BITS   = srdd_pkg::DEF_COL_BITS,
   parameter int VALUE_BITS = srdd_pkg::DEF_VALUE_BITS,
   parameter int ACC_BITS   = 2 * srdd_pkg::DEF_VALUE_BITS + 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  srdd_pkg::mac_ctrl_type              ctrl,
   input  logic [COL_BITS-1:0]                 rd_col,
   input  logic signed [VALUE_BITS-1:0]        rd_val,
   input  logic [COL_BITS-1:0]                 a_col,
   input  logic signed [VALUE_BITS-1:0]        a_val,
   input  logic [COL_BITS-1:0]                 key,
   output logic signed [srdd_pkg::RES_BITS-1:0] sum_sat,
   output logic signed [VALUE_BITS-1:0]        look_val,
   output srdd_pkg::mac_stat_type              stat
);
   import srdd_pkg::*;

   localparam int PROD_BITS = 2 * VALUE_BITS;

   logic                        match;
   logic signed [VALUE_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0] prod_in, prod_ff;
   logic                        v2_in, v2_ff;
   logic                        dbl_in, dbl_ff;
   logic                        found_in, found_ff;
   logic signed [VALUE_BITS-1:0] look_in, look_ff;
   logic signed [ACC_BITS-1:0]  prod_ext, acc_in, acc_ff;
   logic                        ovf;

   always_comb begin
      match = 1'b0;
      mul_b = a_val;
      unique case (ctrl.kind)
         KIND_SQ: begin
            match = 1'b1;
            mul_b = rd_val;
         end
         KIND_CROSS: match = (rd_col == a_col);
         default:    match = 1'b0;
      endcase
      prod_in = rd_val * mul_b;
      v2_in   = ctrl.valid && match;
      dbl_in  = ctrl.dist_mode && (ctrl.kind == KIND_CROSS);
   end

   // Only the first matching entry of a row answers a lookup.
   always_comb begin
      found_in = found_ff;
      look_in  = look_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (ctrl.valid && (ctrl.kind == KIND_LOOK) && (rd_col == key) && !found_ff) begin
         found_in = 1'b1;
         look_in  = rd_val;
      end
   end

   always_comb begin
      prod_ext = ACC_BITS'(prod_ff);
      acc_in   = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = dbl_ff ? acc_ff - (prod_ext <<< 1) : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         v2_ff    <= v2_in;
         found_ff <= found_in;
      end
      prod_ff <= prod_in;
      dbl_ff  <= dbl_in;
      look_ff <= look_in;
      acc_ff  <= acc_in;
   end

   assign ovf = (acc_ff[ACC_BITS-1:RES_BITS-1] !=
                 {(ACC_BITS-RES_BITS+1){acc_ff[ACC_BITS-1]}});

   always_comb begin
      if (ovf) begin
         sum_sat = acc_ff[ACC_BITS-1] ? {1'b1, {(RES_BITS-1){1'b0}}}
                                      : {1'b0, {(RES_BITS-1){1'b1}}};
      end else begin
         sum_sat = acc_ff[RES_BITS-1:0];
      end
   end

   assign look_val   = look_ff;
   assign stat.busy  = v2_ff;
   assign stat.found = found_ff;

endmodule

// File: rtl/core/sparse_row_store_dot_distance_top.sv
// Top level of the compressed sparse row store with lookup, dot product and distance queries.
//
// One request is taken at a time and answered by exactly one response; req_stall stays high
// from acceptance until the response is loaded into the output register, which can still be
// waiting while the next request is taken. An insert fills in the start offsets of the rows
// up to its own that are not yet stored and then writes the entry. A lookup walks the entries
// of its row. A dot product walks the whole second row once for each entry of the first, and
// a distance first walks both rows once more for the sums of squares. This follows from the
// single read port of the entry store, walked one entry a cycle, and the one shared multiplier
// behind it. Errors and a distance of a row with itself answer without reading the store. No
// clearing pass runs after reset.
module sparse_row_store_dot_distance_top #(
   parameter int MAX_ENTRIES = srdd_pkg::DEF_MAX_ENTRIES,
   parameter int MAX_ROWS    = srdd_pkg::DEF_MAX_ROWS,
   parameter int COL_BITS    = srdd_pkg::DEF_COL_BITS,
   parameter int VALUE_BITS  = srdd_pkg::DEF_VALUE_BITS,
   parameter int FRAC_BITS   = srdd_pkg::DEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  srdd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output srdd_pkg::rsp_type rsp_data
);
   import srdd_pkg::*;

   localparam int EI_W     = $clog2(MAX_ENTRIES);
   localparam int EA_W     = $clog2(MAX_ENTRIES + 1);
   localparam int RI_W     = $clog2(MAX_ROWS);
   localparam int RC_W     = $clog2(MAX_ROWS + 1);
   localparam int RCMP_W   = (RC_W > 9) ? RC_W : 9;
   localparam int ACC_BASE = 2 * VALUE_BITS + 2 * EA_W + 3;
   localparam int ACC_BITS = (ACC_BASE > RES_BITS) ? ACC_BASE : RES_BITS + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FILL   = 3'd1;
   localparam logic [2:0] ST_BOUND  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_OUTER  = 3'd4;
   localparam logic [2:0] ST_LATCH  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   localparam logic [1:0] PH_SQA   = 2'd0;
   localparam logic [1:0] PH_SQB   = 2'd1;
   localparam logic [1:0] PH_CROSS = 2'd2;
   localparam logic [1:0] PH_LOOK  = 2'd3;

   logic [COL_BITS-1:0]          col_mem [MAX_ENTRIES];
   logic signed [VALUE_BITS-1:0] val_mem [MAX_ENTRIES];
   logic [EA_W-1:0]              row_mem [MAX_ROWS];

   logic [2:0]                   state_in, state_ff;
   logic [1:0]                   cmd_in, cmd_ff;
   logic [7:0]                   ra_in, ra_ff, rb_in, rb_ff;
   logic [COL_BITS-1:0]          key_in, key_ff;
   logic signed [VALUE_BITS-1:0] val_in, val_ff;
   logic [1:0]                   status_in, status_ff;
   logic signed [RES_BITS-1:0]   res_in, res_ff;
   logic [RC_W-1:0]              row_count_in, row_count_ff;
   logic [EA_W-1:0]              entry_count_in, entry_count_ff;
   logic [2:0]                   bstep_in, bstep_ff;
   logic [EA_W-1:0]              a_start_in, a_start_ff, a_end_in, a_end_ff;
   logic [EA_W-1:0]              b_start_in, b_start_ff, b_end_in, b_end_ff;
   logic [EA_W-1:0]              ptr_in, ptr_ff, end_in, end_ff, i_in, i_ff;
   logic [1:0]                   phase_in, phase_ff;
   logic                         v1_in, v1_ff;
   logic [1:0]                   kind1_in, kind1_ff;
   logic [COL_BITS-1:0]          a_col_in, a_col_ff;
   logic signed [VALUE_BITS-1:0] a_val_in, a_val_ff;
   logic                         rsp_valid_in, rsp_valid_ff;
   rsp_type                      rsp_data_in, rsp_data_ff;

   logic [COL_BITS-1:0]          rd_col_ff;
   logic signed [VALUE_BITS-1:0] rd_val_ff;
   logic [EA_W-1:0]              rs_rd_ff;
   logic [EI_W-1:0]              rd_addr;
   logic [RI_W-1:0]              rs_addr;
   logic                         ent_we, row_we;
   logic                         mac_clear;

   logic [RCMP_W-1:0]            rc_x, ra_req_x, rb_req_x, ra_x, rb_x;
   logic                         req_accept;

   mac_ctrl_type                 mac_ctrl;
   mac_stat_type                 mac_stat;
   logic signed [RES_BITS-1:0]   sum_sat;
   logic signed [VALUE_BITS-1:0] look_val;
   logic signed [RES_BITS-1:0]   look_ext, look_shift;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);

   assign rc_x     = RCMP_W'(row_count_ff);
   assign ra_req_x = RCMP_W'(req_data.row_a);
   assign rb_req_x = RCMP_W'(req_data.row_b);
   assign ra_x     = RCMP_W'(ra_ff);
   assign rb_x     = RCMP_W'(rb_ff);

   assign look_ext   = RES_BITS'(look_val);
   assign look_shift = look_ext <<< FRAC_BITS;

   // Entry store: one write and one read address a cycle, read data registered.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         col_mem[entry_count_ff[EI_W-1:0]] <= key_ff;
         val_mem[entry_count_ff[EI_W-1:0]] <= val_ff;
      end
      rd_col_ff <= col_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_count_ff[RI_W-1:0]] <= entry_count_ff;
      end
      rs_rd_ff <= row_mem[rs_addr];
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      ra_in          = ra_ff;
      rb_in          = rb_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      status_in      = status_ff;
      res_in         = res_ff;
      row_count_in   = row_count_ff;
      entry_count_in = entry_count_ff;
      bstep_in       = bstep_ff;
      a_start_in     = a_start_ff;
      a_end_in       = a_end_ff;
      b_start_in     = b_start_ff;
      b_end_in       = b_end_ff;
      ptr_in         = ptr_ff;
      end_in         = end_ff;
      i_in           = i_ff;
      phase_in       = phase_ff;
      v1_in          = 1'b0;
      kind1_in       = kind1_ff;
      a_col_in       = a_col_ff;
      a_val_in       = a_val_ff;
      rd_addr        = ptr_ff[EI_W-1:0];
      rs_addr        = RI_W'(ra_ff);
      ent_we         = 1'b0;
      row_we         = 1'b0;
      mac_clear      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_data.cmd;
               ra_in     = req_data.row_a;
               rb_in     = req_data.row_b;
               key_in    = COL_BITS'(req_data.column);
               val_in    = VALUE_BITS'($signed(req_data.entry_value));
               status_in = STAT_OK;
               res_in    = '0;
               bstep_in  = 3'd0;
               mac_clear = 1'b1;
               unique case (req_data.cmd)
                  CMD_INSERT: begin
                     priority if ((rc_x != '0) && (ra_req_x + RCMP_W'(1) < rc_x)) begin
                        status_in = STAT_ORDER;
                        state_in  = ST_DONE;
                     end else if ((entry_count_ff >= EA_W'(MAX_ENTRIES)) ||
                                  (ra_req_x >= RCMP_W'(MAX_ROWS))) begin
                        status_in = STAT_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_FILL;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (ra_req_x >= rc_x) begin
                        status_in = STAT_NO_ROW;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_BOUND;
                     end
                  end
                  CMD_DOT, CMD_DIST: begin
                     priority if ((ra_req_x >= rc_x) || (rb_req_x >= rc_x)) begin
                        status_in = STAT_NO_ROW;
                        state_in  = ST_DONE;
                     end else if ((req_data.cmd == CMD_DIST) &&
                                  (req_data.row_a == req_data.row_b)) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_BOUND;
                     end
                  end
               endcase
            end
         end

         // Rows up to and including the target row that are not yet stored get the current entry count as their start.
         ST_FILL: begin
            if (rc_x <= ra_x) begin
               row_we       = 1'b1;
               row_count_in = row_count_ff + 1'b1;
            end else begin
               ent_we         = 1'b1;
               entry_count_in = entry_count_ff + 1'b1;
               state_in       = ST_DONE;
            end
         end

         // Each step but the last issues one offset read; each step but the first takes in the data of the step before.
         ST_BOUND: begin
            bstep_in = bstep_ff + 3'd1;
            unique case (bstep_ff)
               3'd0: rs_addr = RI_W'(ra_ff);
               3'd1: begin
                  rs_addr    = RI_W'(ra_x + RCMP_W'(1));
                  a_start_in = rs_rd_ff;
               end
               3'd2: begin
                  rs_addr  = RI_W'(rb_ff);
                  a_end_in = (ra_x + RCMP_W'(1) < rc_x) ? rs_rd_ff : entry_count_ff;
               end
               3'd3: begin
                  rs_addr    = RI_W'(rb_x + RCMP_W'(1));
                  b_start_in = rs_rd_ff;
               end
               default: begin
                  b_end_in = (rb_x + RCMP_W'(1) < rc_x) ? rs_rd_ff : entry_count_ff;
                  ptr_in   = a_start_ff;
                  end_in   = a_end_ff;
                  i_in     = a_start_ff;
                  if (cmd_ff == CMD_DOT) begin
                     state_in = ST_OUTER;
                  end else begin
                     phase_in = (cmd_ff == CMD_LOOKUP) ? PH_LOOK : PH_SQA;
                     state_in = ST_SCAN;
                  end
               end
            endcase
         end

         ST_SCAN: begin
            if (ptr_ff < end_ff) begin
               v1_in   = 1'b1;
               rd_addr = ptr_ff[EI_W-1:0];
               ptr_in  = ptr_ff + 1'b1;
               unique case (phase_ff)
                  PH_LOOK:  kind1_in = KIND_LOOK;
                  PH_CROSS: kind1_in = KIND_CROSS;
                  default:  kind1_in = KIND_SQ;
               endcase
            end else begin
               unique case (phase_ff)
                  PH_LOOK: state_in = ST_FINISH;
                  PH_SQA: begin
                     ptr_in   = b_start_ff;
                     end_in   = b_end_ff;
                     phase_in = PH_SQB;
                  end
                  PH_SQB: begin
                     i_in     = a_start_ff;
                     state_in = ST_OUTER;
                  end
                  PH_CROSS: begin
                     i_in     = i_ff + 1'b1;
                     state_in = ST_OUTER;
                  end
               endcase
            end
         end

         ST_OUTER: begin
            if (i_ff < a_end_ff) begin
               rd_addr  = i_ff[EI_W-1:0];
               state_in = ST_LATCH;
            end else begin
               state_in = ST_FINISH;
            end
         end

         // The entry of the first row stays fixed while the second row is walked.
         ST_LATCH: begin
            a_col_in = rd_col_ff;
            a_val_in = rd_val_ff;
            ptr_in   = b_start_ff;
            end_in   = b_end_ff;
            phase_in = PH_CROSS;
            state_in = ST_SCAN;
         end

         ST_FINISH: begin
            if (!v1_ff && !mac_stat.busy) begin
               if (cmd_ff == CMD_LOOKUP) begin
                  res_in = mac_stat.found ? look_shift : '0;
               end else begin
                  res_in = sum_sat;
               end
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = status_ff;
               rsp_data_in.result_value    = res_ff;
               rsp_data_in.rows_stored     = 9'(row_count_ff);
               rsp_data_in.entries_stored  = 11'(entry_count_ff);
               state_in                    = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_count_ff   <= '0;
         entry_count_ff <= '0;
         v1_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         bstep_ff       <= 3'd0;
         phase_ff       <= PH_SQA;
      end else begin
         state_ff       <= state_in;
         row_count_ff   <= row_count_in;
         entry_count_ff <= entry_count_in;
         v1_ff          <= v1_in;
         rsp_valid_ff   <= rsp_valid_in;
         bstep_ff       <= bstep_in;
         phase_ff       <= phase_in;
      end
      cmd_ff      <= cmd_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      res_ff      <= res_in;
      a_start_ff  <= a_start_in;
      a_end_ff    <= a_end_in;
      b_start_ff  <= b_start_in;
      b_end_ff    <= b_end_in;
      ptr_ff      <= ptr_in;
      end_ff      <= end_in;
      i_ff        <= i_in;
      kind1_ff    <= kind1_in;
      a_col_ff    <= a_col_in;
      a_val_ff    <= a_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign mac_ctrl.valid     = v1_ff;
   assign mac_ctrl.kind      = kind1_ff;
   assign mac_ctrl.clear     = mac_clear;
   assign mac_ctrl.dist_mode = (cmd_ff == CMD_DIST);

   srdd_mac #(
      .COL_BITS  (COL_BITS),
      .VALUE_BITS(VALUE_BITS),
      .ACC_BITS  (ACC_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .rd_col  (rd_col_ff),
      .rd_val  (rd_val_ff),
      .a_col   (a_col_ff),
      .a_val   (a_val_ff),
      .key     (key_ff),
      .sum_sat (sum_sat),
      .look_val(look_val),
      .stat    (mac_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new transaction must never find reads or products of the last one in flight.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!v1_ff && !mac_stat.busy))
      else $error("pipeline not empty while idle");

   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= EA_W'(MAX_ENTRIES))
      else $error("entry count beyond store depth");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ent_we |=> (entry_count_ff == $past(entry_count_ff) + 1'b1))
      else $error("insert did not advance the entry count");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != STAT_OK)) |-> (rsp_data_ff.result_value == '0))
      else $error("error response carries a non-zero result");

endmodule
